// ===== src/ierq_pkg.sv =====
package ierq_pkg;

    // Command codes
    localparam logic [1:0] CMD_POST  = 2'd0;
    localparam logic [1:0] CMD_TAKE  = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    // Post status codes
    localparam logic [1:0] ST_STORED     = 2'd0;
    localparam logic [1:0] ST_DROPPED    = 2'd1;
    localparam logic [1:0] ST_SUPPRESSED = 2'd2;

    localparam logic [7:0] REPEAT_MASK_RESET = 8'd128;

    // One stored slot: event word and stamp side by side
    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  modifiers;
        logic [7:0]  device;
        logic [15:0] key_code;
        logic [31:0] raw_code;
    } slot_t;

endpackage

// ===== src/input_event_ring_queue_top.sv =====
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    command, raw_code, key_code, source_device,
//                                             modifier_bits, stamp
// output    out        out_valid / out_stall  found, out_raw_code, out_key_code, out_device,
//                                             out_modifiers, out_stamp, post_status
// config    in         cfg_valid / cfg_ready  cfg_data (repeat_mask)
//
// Each request passes from acceptance through the slot memory read stage and
// then the output register to its result. Requests are accepted every cycle
// while in_stall is low; the throughput limit is the single memory read stage,
// which holds when the output register is stalled and full.
// Reset clears the pointers, the stage valids and sets repeat_mask to 128;
// the slot memory is not cleared, since a slot is read only after it is written.
// An output stall backs up into in_stall in the same cycle once the read stage and the output register are both full.
module input_event_ring_queue_top #(
    parameter int DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] raw_code,
    input  logic [15:0] key_code,
    input  logic [7:0]  source_device,
    input  logic [7:0]  modifier_bits,
    input  logic [31:0] stamp,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [31:0] out_raw_code,
    output logic [15:0] out_key_code,
    output logic [7:0]  out_device,
    output logic [7:0]  out_modifiers,
    output logic [31:0] out_stamp,
    output logic [1:0]  post_status,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    // Slot memory, one write and one read port
    ierq_pkg::slot_t slot_mem [DEPTH];
    ierq_pkg::slot_t rd_slot_reg;

    logic [PTR_W-1:0] write_ptr_reg, write_ptr_next;
    logic [PTR_W-1:0] read_ptr_reg, read_ptr_next;
    logic [7:0]       repeat_mask_reg;

    // Read stage: request waiting on memory data
    logic             s1_valid_reg;
    logic             s1_found_reg;
    logic [1:0]       s1_status_reg;
    logic             s1_found_next;
    logic [1:0]       s1_status_next;

    // Output register
    logic             out_valid_reg;
    logic             found_reg;
    logic [1:0]       status_reg;
    ierq_pkg::slot_t  out_slot_reg;

    logic             in_accept;
    logic             s1_move;
    logic             queue_empty;
    logic             mem_wr_en;
    logic             mem_rd_en;
    logic [PTR_W-1:0] write_ptr_adv;
    logic [PTR_W-1:0] read_ptr_adv;
    ierq_pkg::slot_t  wr_slot;

    // Move the read stage into the output register whenever that register is free
    assign s1_move   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign queue_empty   = (write_ptr_reg == read_ptr_reg);
    assign write_ptr_adv = (write_ptr_reg == PTR_LAST) ? '0 : write_ptr_reg + 1'b1;
    assign read_ptr_adv  = (read_ptr_reg == PTR_LAST) ? '0 : read_ptr_reg + 1'b1;

    assign wr_slot.stamp     = stamp;
    assign wr_slot.modifiers = modifier_bits;
    assign wr_slot.device    = source_device;
    assign wr_slot.key_code  = key_code;
    assign wr_slot.raw_code  = raw_code;

    // Decode the request: pointer updates, memory access and status
    always_comb
    begin
        write_ptr_next = write_ptr_reg;
        read_ptr_next  = read_ptr_reg;
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;
        s1_found_next  = 1'b0;
        s1_status_next = ierq_pkg::ST_STORED;
        if (in_accept)
        begin
            case (command)
                ierq_pkg::CMD_POST:
                begin
                    if (!queue_empty && ((modifier_bits & repeat_mask_reg) != 8'd0))
                    begin
                        // drop auto-repeat while events are pending
                        s1_status_next = ierq_pkg::ST_SUPPRESSED;
                    end
                    else
                    begin
                        mem_wr_en      = 1'b1;
                        write_ptr_next = write_ptr_adv;
                        if (write_ptr_adv == read_ptr_reg)
                        begin
                            // full: discard the oldest event
                            read_ptr_next  = read_ptr_adv;
                            s1_status_next = ierq_pkg::ST_DROPPED;
                        end
                    end
                end
                ierq_pkg::CMD_TAKE:
                begin
                    if (!queue_empty)
                    begin
                        mem_rd_en     = 1'b1;
                        s1_found_next = 1'b1;
                        read_ptr_next = read_ptr_adv;
                    end
                end
                ierq_pkg::CMD_FLUSH:
                begin
                    write_ptr_next = '0;
                    read_ptr_next  = '0;
                end
                default:
                begin
                    // unused code: no operation
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            slot_mem[write_ptr_reg] <= wr_slot;
        end
    end

    // Registered read; holds while the read stage is stalled
    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            rd_slot_reg <= slot_mem[read_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_ptr_reg   <= '0;
            read_ptr_reg    <= '0;
            repeat_mask_reg <= ierq_pkg::REPEAT_MASK_RESET;
            s1_valid_reg    <= 1'b0;
            s1_found_reg    <= 1'b0;
            s1_status_reg   <= ierq_pkg::ST_STORED;
            out_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            status_reg      <= ierq_pkg::ST_STORED;
        end
        else
        begin
            write_ptr_reg <= write_ptr_next;
            read_ptr_reg  <= read_ptr_next;
            if (cfg_valid && cfg_ready)
            begin
                repeat_mask_reg <= cfg_data;
            end
            if (in_accept)
            begin
                s1_valid_reg  <= 1'b1;
                s1_found_reg  <= s1_found_next;
                s1_status_reg <= s1_status_next;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
                found_reg     <= s1_found_reg;
                status_reg    <= s1_status_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output register; zero when nothing was taken
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_slot_reg <= s1_found_reg ? rd_slot_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign post_status   = status_reg;
    assign out_raw_code  = out_slot_reg.raw_code;
    assign out_key_code  = out_slot_reg.key_code;
    assign out_device    = out_slot_reg.device;
    assign out_modifiers = out_slot_reg.modifiers;
    assign out_stamp     = out_slot_reg.stamp;

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (write_ptr_reg <= PTR_LAST) && (read_ptr_reg <= PTR_LAST))
        else $error("queue pointer out of range");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && command == ierq_pkg::CMD_FLUSH)
        |=> (write_ptr_reg == '0) && (read_ptr_reg == '0))
        else $error("flush did not clear pointers");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (out_raw_code == 32'd0) && (out_key_code == 16'd0)
        && (out_device == 8'd0) && (out_modifiers == 8'd0) && (out_stamp == 32'd0))
        else $error("result without event carries data");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (post_status == ierq_pkg::ST_STORED))
        else $error("take result with post status");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> s1_valid_reg && $stable(s1_found_reg)
        && $stable(s1_status_reg))
        else $error("read stage lost a request");

endmodule
